### rtl/srde_pkg.sv
// Shared types, constants and helpers for the signed radix digit emitter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package srde_pkg;

	localparam int VAL_W     = 32;               // input value width
	localparam int CHR_W     = 8;                // output character width
	localparam int BASE_W    = 5;                // alphabet_size register width
	localparam int DIG_W     = 4;                // one radix digit
	localparam int MAX_BASE  = 16;
	localparam int NUM_CHARS = 16;
	localparam int NUM_CELLS = 32;               // enough digits for 2**31 in base 2
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 64;
	localparam int CONV_CYCLES = VAL_W + NUM_CELLS - 1;

	localparam logic [CHR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHR_W-1:0] CHAR_MINUS = 8'h2D;

	// register index, taken from paddr[4:3]
	localparam logic [1:0] REG_SIZE  = 2'd0;
	localparam logic [1:0] REG_DLOW  = 2'd1;
	localparam logic [1:0] REG_DHIGH = 2'd2;

	// carry link between neighboring digit cells
	typedef struct packed {
		logic vld;
		logic data;
	} carry_t;

	function automatic logic [CHR_W-1:0] char_at(
		input logic [NUM_CHARS*CHR_W-1:0] chars,
		input logic [DIG_W-1:0] idx
	);
		return chars[idx*CHR_W +: CHR_W];
	endfunction

endpackage

`default_nettype wire

### rtl/srde_cell.sv
// One digit cell of the systolic binary-to-radix converter.
// Depends on srde_pkg (carry_t, widths).
`default_nettype none

module srde_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          shift,
	input  logic [srde_pkg::BASE_W-1:0]   base,
	input  srde_pkg::carry_t              cin,
	input  logic [srde_pkg::DIG_W-1:0]    shift_in,
	output srde_pkg::carry_t              cout,
	output logic [srde_pkg::DIG_W-1:0]    digit
);
	import srde_pkg::*;

	logic [DIG_W-1:0]  digit_q;
	carry_t            cout_q;
	logic [BASE_W-1:0] dbl;
	logic [BASE_W-1:0] red;
	logic              ge;

	// digit*2 + carry; digit < base so one conditional subtract keeps it in range
	always_comb begin
		dbl = {digit_q, cin.data};
		ge  = (dbl >= base);
		red = dbl - base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout_q <= '0;
		end else if (clr) begin
			cout_q <= '0;
		end else begin
			cout_q.vld  <= cin.vld;
			cout_q.data <= cin.vld & ge;
		end
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			digit_q <= '0;
		end else if (shift) begin
			digit_q <= shift_in;
		end else if (cin.vld) begin
			digit_q <= ge ? red[DIG_W-1:0] : dbl[DIG_W-1:0];
		end
	end

	assign cout  = cout_q;
	assign digit = digit_q;

endmodule

`default_nettype wire

### rtl/srde_alpha.sv
// Alphabet checker: walks the digit characters one per cycle and flags
// zero bytes, sign characters, repeats and an out-of-range base. Uses srde_pkg.
`default_nettype none

module srde_alpha (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [srde_pkg::BASE_W-1:0]                 size,
	input  logic [srde_pkg::NUM_CHARS*srde_pkg::CHR_W-1:0] chars,
	output logic                                        ok
);
	import srde_pkg::*;

	logic [DIG_W-1:0] idx_q;
	logic             run_q;
	logic             ok_q;
	logic             bad;
	logic [CHR_W-1:0] cur;

	always_comb begin
		cur = char_at(chars, idx_q);
		bad = (cur == '0) || (cur == CHAR_PLUS) || (cur == CHAR_MINUS);
		for (int j = 0; j < NUM_CHARS; j++) begin
			if ((DIG_W'(j) > idx_q) && (BASE_W'(j) < size)
				&& (char_at(chars, DIG_W'(j)) == cur)) begin
				bad = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			run_q <= 1'b0;
			ok_q  <= 1'b0;
		end else if (start) begin
			idx_q <= '0;
			run_q <= 1'b1;
			ok_q  <= (size >= BASE_W'(2)) && (size <= BASE_W'(MAX_BASE));
		end else if (run_q) begin
			if (({1'b0, idx_q} < size) && bad) begin
				ok_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
			if (idx_q == DIG_W'(NUM_CHARS - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	assign ok = ok_q;

endmodule

`default_nettype wire

### rtl/signed_radix_digit_emitter.sv
// Signed radix digit emitter: top level with registers, control and output beat.
// Depends on srde_pkg, srde_cell and srde_alpha.
//
// Usage:
//   Input channel in_valid/in_ready carries one signed 32-bit value per beat.
//   Output channel out_valid/out_ready carries one character per beat: a '-'
//   for negative values, then the digits most significant first; final_res
//   marks the last character of the number. Nothing is sent for a bad alphabet.
//   Registers (APB, 64-bit data): 0x00 alphabet_size, 0x08 digits_low, 0x10
//   digits_high, to be written only while idle; the block does not enforce this.
// Conversion:
//   The magnitude is fed one bit per cycle into a row of 32 digit cells whose
//   carries ripple one cell per cycle. Readout, after the sign beat of a
//   negative value, then shifts the digit row by one position per cycle while
//   the receiver is ready to take beats; in_ready is high only when idle.
// Reset clears the registers to zero and the control to idle. A stalled
// receiver holds the output beat and pauses readout; leading zeros are
// skipped without waiting on the receiver.
`default_nettype none

module signed_radix_digit_emitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [srde_pkg::VAL_W-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [srde_pkg::CHR_W-1:0]      character,
	output logic                            final_res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [srde_pkg::ADDR_W-1:0]     paddr,
	input  logic [srde_pkg::DATA_W-1:0]     pwdata,
	output logic [srde_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);
	import srde_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_SIGN,
		S_DIGS
	} state_t;

	state_t                       state_q;
	logic [BASE_W-1:0]            size_q;
	logic [DATA_W-1:0]            dlow_q;
	logic [DATA_W-1:0]            dhigh_q;
	logic [NUM_CHARS*CHR_W-1:0]   chars;
	logic [VAL_W-1:0]             mag_q;
	logic                         neg_q;
	logic [5:0]                   cnt_q;
	logic [5:0]                   rem_q;
	logic                         started_q;
	logic                         out_valid_q;
	logic [CHR_W-1:0]             char_q;
	logic                         final_q;

	logic                         accept;
	logic                         cfg_wr;
	logic                         alpha_ok;
	logic                         slot_free;
	logic                         lead;
	logic                         act;
	logic                         shift;
	logic                         emit;
	logic [VAL_W-1:0]             raw;
	logic [DIG_W-1:0]             top;

	carry_t                       link  [NUM_CELLS];
	logic [DIG_W-1:0]             digit [NUM_CELLS];

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign chars  = {dhigh_q, dlow_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= '0;
			dlow_q  <= '0;
			dhigh_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_SIZE:  size_q  <= pwdata[BASE_W-1:0];
				REG_DLOW:  dlow_q  <= pwdata;
				REG_DHIGH: dhigh_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_SIZE:  prdata = {{(DATA_W-BASE_W){1'b0}}, size_q};
			REG_DLOW:  prdata = dlow_q;
			REG_DHIGH: prdata = dhigh_q;
			default:   prdata = '0;
		endcase
	end

	// ---------------- datapath ----------------
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign raw       = value;
	assign slot_free = !out_valid_q || out_ready;
	assign top       = digit[NUM_CELLS-1];
	assign lead      = (top == '0) && !started_q && (rem_q != 6'd1);
	assign act       = (state_q == S_DIGS) && (lead || slot_free);
	assign shift     = act;
	// a new output beat is loaded: the sign, or a digit past the leading zeros
	assign emit      = ((state_q == S_SIGN) && slot_free) || (act && !lead);

	// magnitude enters cell 0 msb first, one bit per cycle
	assign link[0].vld  = (state_q == S_CONV) && (cnt_q < 6'(VAL_W));
	assign link[0].data = mag_q[VAL_W-1];

	for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
		if (j < NUM_CELLS - 1) begin : g_mid
			srde_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clr      (accept),
				.shift    (shift),
				.base     (size_q),
				.cin      (link[j]),
				.shift_in ((j == 0) ? {DIG_W{1'b0}} : digit[(j == 0) ? 0 : j-1]),
				.cout     (link[j+1]),
				.digit    (digit[j])
			);
		end else begin : g_top
			srde_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clr      (accept),
				.shift    (shift),
				.base     (size_q),
				.cin      (link[j]),
				.shift_in (digit[j-1]),
				.cout     (),
				.digit    (digit[j])
			);
		end
	end

	srde_alpha u_alpha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.size   (size_q),
		.chars  (chars),
		.ok     (alpha_ok)
	);

	// ---------------- control and output beat ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(CONV_CYCLES - 1)) begin
						rem_q     <= 6'(NUM_CELLS);
						started_q <= 1'b0;
						if (!alpha_ok) begin
							state_q <= S_IDLE;
						end else if (neg_q) begin
							state_q <= S_SIGN;
						end else begin
							state_q <= S_DIGS;
						end
					end
				end
				S_SIGN: begin
					if (slot_free) begin
						state_q <= S_DIGS;
					end
				end
				S_DIGS: begin
					if (act) begin
						rem_q <= rem_q - 1'b1;
						if (!lead) begin
							started_q <= 1'b1;
						end
						if (rem_q == 6'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[VAL_W-1];
			mag_q <= raw[VAL_W-1] ? (VAL_W'(0) - raw) : raw;
		end else if (state_q == S_CONV) begin
			mag_q <= {mag_q[VAL_W-2:0], 1'b0};
		end
		if ((state_q == S_SIGN) && slot_free) begin
			char_q  <= CHAR_MINUS;
			final_q <= 1'b0;
		end else if (act && !lead) begin
			char_q  <= char_at(chars, top);
			final_q <= (rem_q == 6'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign final_res = final_q;

endmodule

`default_nettype wire

### rtl/srde_checker.sv
// Port-level assertions for the signed radix digit emitter, bound to the top.
// Depends on srde_pkg for widths and the minus character.
`default_nettype none

module srde_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [srde_pkg::CHR_W-1:0]   character,
	input logic                         final_res
);
	import srde_pkg::*;

	// a held beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(final_res))
		else $error("output beat changed while stalled");

	// one value at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice back to back");

	// more characters of this number are pending, so no new value is taken
	a_mid_number: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_res |-> !in_ready)
		else $error("ready while a number is only partly sent");

	// a valid alphabet never holds a zero byte
	a_no_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> character != '0)
		else $error("zero byte sent");

	// the minus sign never ends a number
	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (character == CHAR_MINUS) |-> !final_res)
		else $error("minus sign flagged as last character");

endmodule

bind signed_radix_digit_emitter srde_checker u_srde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.character (character),
	.final_res (final_res)
);

`default_nettype wire
